// ===== hdl/atl_pkg.sv =====
// shared types, constants and the cordic angle table for the tilt angle block
`default_nettype none

package atl_pkg;

    // input sample, raw two's complement counts
    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } sample_t;

    // result: angles in degrees, fixed point
    typedef struct packed {
        logic signed [15:0] pitch_deg;
        logic signed [15:0] roll_deg;
        logic        [15:0] tilt_deg;
    } angle_t;

    localparam int CORDIC_STEPS = 18;
    localparam int ACC_FRAC     = 16;
    localparam int ANG_W        = 25;   // degree accumulator, 16 fraction bits
    localparam int RAD_W        = 24;   // radius, 8 fraction bits
    localparam int NUM_W        = 24;   // numerator, raw count times 2^8

    // round(atan(2^-i) * 180/pi * 2^16)
    function automatic logic signed [ANG_W-1:0] atan_deg(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:  v = 25'sd2949120;
            1:  v = 25'sd1740967;
            2:  v = 25'sd919879;
            3:  v = 25'sd466945;
            4:  v = 25'sd234379;
            5:  v = 25'sd117304;
            6:  v = 25'sd58666;
            7:  v = 25'sd29335;
            8:  v = 25'sd14668;
            9:  v = 25'sd7334;
            10: v = 25'sd3667;
            11: v = 25'sd1833;
            12: v = 25'sd917;
            13: v = 25'sd458;
            14: v = 25'sd229;
            15: v = 25'sd115;
            16: v = 25'sd57;
            17: v = 25'sd29;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/atl_isqrt.sv =====
// pipelined integer square root, one result bit per stage, with sideband
`default_nettype none

module atl_isqrt
    import atl_pkg::*;
#(
    parameter int RW = 48,
    parameter int SW = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [RW-1:0]   in_rad,
    input  wire logic [SW-1:0]   in_side,
    output logic                 out_valid,
    output logic [RW/2-1:0]      out_root,
    output logic [SW-1:0]        out_side
);

    localparam int N   = RW / 2;
    localparam int RMW = N + 3;

    logic            valid_reg [N];
    logic [RW-1:0]   rad_reg   [N];
    logic [RMW-1:0]  rem_reg   [N];
    logic [N-1:0]    root_reg  [N];
    logic [SW-1:0]   side_reg  [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic            v_in;
        logic [RW-1:0]   rad_in;
        logic [RMW-1:0]  rem_in;
        logic [N-1:0]    root_in;
        logic [SW-1:0]   side_in;
        logic [RMW-1:0]  r_sh;
        logic [RMW-1:0]  trial;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rad_in  = in_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = valid_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign r_sh  = {rem_in[RMW-3:0], rad_in[RW-1 -: 2]};
        assign trial = RMW'({root_in, 2'b01});

        // valid travels with the stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= v_in;
            end
        end

        // one root bit decided per stage
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (r_sh >= trial)
                begin
                    rem_reg[k]  <= r_sh - trial;
                    root_reg[k] <= {root_in[N-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= r_sh;
                    root_reg[k] <= {root_in[N-2:0], 1'b0};
                end
                rad_reg[k]  <= rad_in << 2;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

`default_nettype wire

// ===== hdl/atl_cordic.sv =====
// pipelined vectoring cordic, angle of (den, num) in degrees
`default_nettype none

module atl_cordic
    import atl_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     en,
    input  wire logic                     in_valid,
    input  wire logic signed [NUM_W-1:0]  num,
    input  wire logic        [RAD_W-1:0]  den,
    output logic                          out_valid,
    output logic signed [ANG_W-1:0]       out_angle
);

    localparam int XW = 28;

    logic                    valid_reg [CORDIC_STEPS];
    logic                    zero_reg  [CORDIC_STEPS];
    logic signed [XW-1:0]    x_reg     [CORDIC_STEPS];
    logic signed [XW-1:0]    y_reg     [CORDIC_STEPS];
    logic signed [ANG_W-1:0] z_reg     [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        logic                    v_in;
        logic                    zero_in;
        logic signed [XW-1:0]    x_in;
        logic signed [XW-1:0]    y_in;
        logic signed [ANG_W-1:0] z_in;
        logic signed [XW-1:0]    xs;
        logic signed [XW-1:0]    ys;

        if (i == 0) begin : g_first
            assign v_in    = in_valid;
            assign zero_in = (den == '0) && (num == '0);
            assign x_in    = {{(XW-RAD_W){1'b0}}, den};
            assign y_in    = {{(XW-NUM_W){num[NUM_W-1]}}, num};
            assign z_in    = '0;
        end else begin : g_next
            assign v_in    = valid_reg[i-1];
            assign zero_in = zero_reg[i-1];
            assign x_in    = x_reg[i-1];
            assign y_in    = y_reg[i-1];
            assign z_in    = z_reg[i-1];
        end

        assign xs = x_in >>> i;
        assign ys = y_in >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= v_in;
            end
        end

        // rotate toward the x axis, accumulate the angle
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!y_in[XW-1])
                begin
                    x_reg[i] <= x_in + ys;
                    y_reg[i] <= y_in - xs;
                    z_reg[i] <= z_in + atan_deg(i);
                end
                else
                begin
                    x_reg[i] <= x_in - ys;
                    y_reg[i] <= y_in + xs;
                    z_reg[i] <= z_in - atan_deg(i);
                end
                zero_reg[i] <= zero_in;
            end
        end
    end

    // an all-zero vector has angle zero
    assign out_valid = valid_reg[CORDIC_STEPS-1];
    assign out_angle = zero_reg[CORDIC_STEPS-1] ? '0 : z_reg[CORDIC_STEPS-1];

endmodule

`default_nettype wire

// ===== hdl/accel_tilt_angle.sv =====
// Pitch, roll and tilt angles from a three-axis accelerometer sample.
//
// Input channel: sample_valid / sample_stall / sample (raw x, y, z counts).
// Output channel: angle_valid / angle_stall / angle (pitch, roll, tilt in
// degrees with ANGLE_FRAC_BITS fraction bits). A transfer happens on a clock
// edge where valid is high and stall is low.
//
// Fully pipelined: one sample accepted every cycle unless the output stalls,
// one result per sample, in order. Stages: squares and sums (2), radius
// square root (24, one bit per stage), cordic arctangent (18), rounding (1),
// tilt squares and sum (2), tilt square root (17), output register (1).
//
// Reset clears all valid bits; no result is in flight afterwards.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and sample_stall is raised in the same cycle; nothing is dropped or
// repeated. Bubbles in the input simply travel down as invalid stages.
`default_nettype none

module accel_tilt_angle
    import atl_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    sample_valid,
    output logic         sample_stall,
    input  wire sample_t sample,
    output logic         angle_valid,
    input  wire logic    angle_stall,
    output angle_t       angle
);

    localparam int SH       = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int LIM      = 90 << ANGLE_FRAC_BITS;
    localparam int POS_LIM  = (LIM < 32767) ? LIM : 32767;
    localparam int NEG_LIM  = (LIM < 32768) ? LIM : 32768;
    localparam int ROOT_W   = 17;

    // round half away from zero, clamp to +/-90 degrees and to 16 bits
    function automatic logic signed [15:0] round_angle(input logic signed [ANG_W-1:0] z);
        logic [ANG_W-1:0] mag;
        logic [ANG_W-1:0] q;
        logic [ANG_W-1:0] m;
        mag = z[ANG_W-1] ? ANG_W'(-z) : ANG_W'(z);
        q   = (mag + ANG_W'(1 << (SH - 1))) >> SH;
        if (z[ANG_W-1])
        begin
            m = (q > ANG_W'(NEG_LIM)) ? ANG_W'(NEG_LIM) : q;
            return 16'(-m);
        end
        else
        begin
            m = (q > ANG_W'(POS_LIM)) ? ANG_W'(POS_LIM) : q;
            return 16'(m);
        end
    endfunction

    logic en;

    // whole pipeline advances unless a finished result is held
    assign en           = !(angle_valid && angle_stall);
    assign sample_stall = !en;

    // stage 1: squares
    logic               s1_valid_reg;
    logic [30:0]        sq_x_reg, sq_y_reg, sq_z_reg;
    logic signed [15:0] s1_ax_reg, s1_ay_reg;
    logic signed [31:0] px, py, pz;

    assign px = sample.accel_x * sample.accel_x;
    assign py = sample.accel_y * sample.accel_y;
    assign pz = sample.accel_z * sample.accel_z;

    // stage 2: radicands with 16 extra fraction bits
    logic               s2_valid_reg;
    logic [47:0]        rad_p_reg, rad_r_reg;
    logic signed [15:0] s2_ax_reg, s2_ay_reg;
    logic [31:0]        sum_p, sum_r;

    assign sum_p = 32'(sq_x_reg) + 32'(sq_z_reg);
    assign sum_r = 32'(sq_y_reg) + 32'(sq_z_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= sample_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_x_reg  <= px[30:0];
            sq_y_reg  <= py[30:0];
            sq_z_reg  <= pz[30:0];
            s1_ax_reg <= sample.accel_x;
            s1_ay_reg <= sample.accel_y;
            rad_p_reg <= {sum_p, 16'h0000};
            rad_r_reg <= {sum_r, 16'h0000};
            s2_ax_reg <= s1_ax_reg;
            s2_ay_reg <= s1_ay_reg;
        end
    end

    // radius square roots, the numerator rides along
    logic              rp_valid, rr_valid;
    logic [RAD_W-1:0]  rp_root, rr_root;
    logic [15:0]       rp_num, rr_num;

    atl_isqrt #(.RW(48), .SW(16)) u_sqrt_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .in_rad    (rad_p_reg),
        .in_side   (s2_ay_reg),
        .out_valid (rp_valid),
        .out_root  (rp_root),
        .out_side  (rp_num)
    );

    atl_isqrt #(.RW(48), .SW(16)) u_sqrt_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .in_rad    (rad_r_reg),
        .in_side   (s2_ax_reg),
        .out_valid (rr_valid),
        .out_root  (rr_root),
        .out_side  (rr_num)
    );

    // arctangents
    logic                    cp_valid, cr_valid;
    logic signed [ANG_W-1:0] cp_angle, cr_angle;

    atl_cordic u_cordic_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rp_valid),
        .num       ({rp_num, 8'h00}),
        .den       (rp_root),
        .out_valid (cp_valid),
        .out_angle (cp_angle)
    );

    atl_cordic u_cordic_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rr_valid),
        .num       ({rr_num, 8'h00}),
        .den       (rr_root),
        .out_valid (cr_valid),
        .out_angle (cr_angle)
    );

    // rounding, tilt squares and tilt radicand
    logic               rd_valid_reg, tq_valid_reg, ts_valid_reg;
    logic signed [15:0] rd_pitch_reg, rd_roll_reg;
    logic signed [15:0] tq_pitch_reg, tq_roll_reg;
    logic [30:0]        tq_psq_reg, tq_rsq_reg;
    logic signed [15:0] ts_pitch_reg, ts_roll_reg;
    logic [33:0]        ts_rad_reg;
    logic signed [31:0] pp, rr;
    logic [31:0]        tsum;

    assign pp   = rd_pitch_reg * rd_pitch_reg;
    assign rr   = rd_roll_reg * rd_roll_reg;
    assign tsum = 32'(tq_psq_reg) + 32'(tq_rsq_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            tq_valid_reg <= 1'b0;
            ts_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            rd_valid_reg <= cp_valid && cr_valid;
            tq_valid_reg <= rd_valid_reg;
            ts_valid_reg <= tq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_pitch_reg <= round_angle(cp_angle);
            rd_roll_reg  <= round_angle(cr_angle);
            tq_psq_reg   <= pp[30:0];
            tq_rsq_reg   <= rr[30:0];
            tq_pitch_reg <= rd_pitch_reg;
            tq_roll_reg  <= rd_roll_reg;
            ts_rad_reg   <= {tsum, 2'b00};
            ts_pitch_reg <= tq_pitch_reg;
            ts_roll_reg  <= tq_roll_reg;
        end
    end

    // tilt square root, angles ride along
    logic              tr_valid;
    logic [ROOT_W-1:0] tr_root;
    logic [31:0]       tr_side;

    atl_isqrt #(.RW(34), .SW(32)) u_sqrt_tilt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ts_valid_reg),
        .in_rad    (ts_rad_reg),
        .in_side   ({ts_pitch_reg, ts_roll_reg}),
        .out_valid (tr_valid),
        .out_root  (tr_root),
        .out_side  (tr_side)
    );

    // halve with round half up, saturate to 16 bits
    logic [ROOT_W-1:0] tilt_half;
    angle_t            angle_next;
    logic              angle_valid_reg;
    angle_t            angle_reg;

    assign tilt_half = ROOT_W'((18'(tr_root) + 18'd1) >> 1);

    always_comb
    begin
        angle_next.pitch_deg = tr_side[31:16];
        angle_next.roll_deg  = tr_side[15:0];
        angle_next.tilt_deg  = tilt_half[ROOT_W-1] ? 16'hFFFF : tilt_half[15:0];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            angle_valid_reg <= tr_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= angle_next;
        end
    end

    assign angle_valid = angle_valid_reg;
    assign angle       = angle_reg;

endmodule

`default_nettype wire

// ===== hdl/atl_checker.sv =====
// port checker for the tilt angle block and its bind
`default_nettype none

module atl_checker
    import atl_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    sample_stall,
    input wire logic    angle_valid,
    input wire logic    angle_stall,
    input wire angle_t  angle
);

    // a held result stays offered
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid && angle_stall |=> angle_valid)
        else $error("result dropped while stalled");

    // a held result does not change
    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid && angle_stall |=> $stable(angle))
        else $error("result changed while stalled");

    // input back-pressure only comes from a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> angle_valid && angle_stall)
        else $error("input stalled without a held result");

    // nonzero pitch or roll gives nonzero tilt
    a_tilt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid && (angle.tilt_deg == 16'h0000) |->
            (angle.pitch_deg == 16'sh0000) && (angle.roll_deg == 16'sh0000))
        else $error("zero tilt with nonzero angle");

endmodule

bind accel_tilt_angle atl_checker u_atl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_stall (sample_stall),
    .angle_valid  (angle_valid),
    .angle_stall  (angle_stall),
    .angle        (angle)
);

`default_nettype wire
